// ===== rtl/fbpa_pkg.sv =====
`default_nettype none

package fbpa_pkg;

    // fixed field widths of the channels and registers
    localparam int BASE_W     = 32;
    localparam int STRIDE_W   = 16;
    localparam int HDR_W      = 8;
    localparam int COUNT_W    = 11;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int REQ_W      = 2;
    localparam int STAT_W     = 3;
    localparam int IN_ADDR_W  = 32;
    localparam int RES_ADDR_W = 32;

    // register reset values
    localparam logic [BASE_W-1:0]   POOL_BASE_RST    = 32'd0;
    localparam logic [STRIDE_W-1:0] BLOCK_STRIDE_RST = 16'd64;
    localparam logic [HDR_W-1:0]    HEADER_BYTES_RST = 8'd8;
    localparam logic [COUNT_W-1:0]  BLOCK_COUNT_RST  = 11'd1024;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_CHECK = 2'd2,
        REQ_INIT  = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_NULL     = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTALLOC = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BASE    = 2'd0,
        CFG_BLOCK_STRIDE = 2'd1,
        CFG_HEADER_BYTES = 2'd2,
        CFG_BLOCK_COUNT  = 2'd3
    } t_cfg_idx;

endpackage

`default_nettype wire

// ===== rtl/fixed_block_pool_allocator_core.sv =====
`default_nettype none

// fixed-size block pool allocator
// input stream: tuser carries the request kind (allocate, free, check, init),
// tdata the user address for free and check. one result transfer per request:
// tdata carries the allocated user address, tuser the success flag and status.
// config port is a plain register write, by the user only while the block idles; unenforced.
// steps per request, paced by the state memory's registered read and the divider:
//   allocate            read link, write back, result; result only when the pool is empty
//   free / check        bit-serial division by the stride, then read the block's entry
//                       and write it back for a free of an allocated block; the result
//                       follows the division when the address lies beyond the pool
//   null, zero stride   result only
//   init                one entry rebuilt per cycle, then the result
// the block takes one request at a time; tready is high while no request is
// in progress, even when a result still waits in the output register.
// reset loads the register defaults and runs the init sweep over all
// MAX_BLOCKS entries with tready low and no result.
// a stalled receiver holds the output register; a finished result then waits
// in its own stage until the output register frees up.
module fixed_block_pool_allocator_core
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024,
    parameter int ADDR_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request channel
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [IN_ADDR_W-1:0]  i_s_tdata,   // [31:0] address
    input  wire logic [REQ_W-1:0]      i_s_tuser,   // [1:0] req_type
    // result channel
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [RES_ADDR_W-1:0]      o_m_tdata,   // [31:0] result_address
    output logic [STAT_W:0]            o_m_tuser,   // [0] success, [3:1] status
    // configuration writes
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;   // block index
    localparam int CW = $clog2(MAX_BLOCKS + 1);                       // free count
    localparam int LW = CW + 1;
    localparam int MW = IW + 1;                                       // {alloc, link}
    localparam int PW = IW + STRIDE_W;                                // index * stride
    localparam int SW0 = (ADDR_WIDTH > PW) ? ADDR_WIDTH : PW;
    localparam int SW = (SW0 > BASE_W) ? SW0 : BASE_W;
    localparam int QW = (ADDR_WIDTH > CW) ? ADDR_WIDTH : CW;
    localparam int EW = (COUNT_W > 32) ? COUNT_W : 32;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ALLOC,
        S_DIV,
        S_LOOK,
        S_RESP
    } t_state;

    // configuration registers
    logic [BASE_W-1:0]   r_pool_base;
    logic [STRIDE_W-1:0] r_block_stride;
    logic [HDR_W-1:0]    r_header_bytes;
    logic [COUNT_W-1:0]  r_block_count;

    // control
    t_state              r_state;
    logic [IW-1:0]       r_sweep;
    logic                r_init_resp;
    logic [IW-1:0]       r_head;
    logic [CW-1:0]       r_free_cnt;
    t_req                r_req;
    logic [IW-1:0]       r_idx;
    logic [PW-1:0]       r_prod;

    // pending result and output register
    logic                  r_res_ok;
    logic [RES_ADDR_W-1:0] r_res_addr;
    t_status               r_res_stat;
    logic                  r_out_valid;
    logic [RES_ADDR_W-1:0] r_out_tdata;
    logic [STAT_W:0]       r_out_tuser;

    // state memory: allocated bit above the free-list link
    logic [MW-1:0] r_mem [MAX_BLOCKS];
    logic [MW-1:0] r_rdata;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [MW-1:0] w_wdata;
    logic [IW-1:0] w_raddr;

    logic [CW-1:0]         w_eff;
    logic [LW-1:0]         w_next;
    logic [IW-1:0]         w_link;
    logic                  w_sweep_last;
    logic [PW-1:0]         w_prod;
    logic [SW-1:0]         w_sum_w;
    logic [ADDR_WIDTH-1:0] w_sum_a;
    logic [RES_ADDR_W-1:0] w_sum;
    logic [ADDR_WIDTH-1:0] w_bytes;
    t_req                  w_in_req;
    logic                  w_in_null;
    logic                  w_accept;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [ADDR_WIDTH-1:0] w_quo;
    logic                  w_q_range;
    logic                  w_hit;

    // effective block count, saturated to the pool depth
    assign w_eff = (EW'(r_block_count) > EW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS)
                                                         : CW'(r_block_count);

    // init sweep: chain each entry to the next, the last counted one and any beyond it to zero
    assign w_next       = LW'(r_sweep) + LW'(1);
    assign w_link       = (w_next < LW'(w_eff)) ? IW'(w_next) : '0;
    assign w_sweep_last = (r_sweep == IW'(MAX_BLOCKS - 1));

    // allocate address: product registered before the add
    assign w_prod  = PW'(r_head) * PW'(r_block_stride);
    assign w_sum_w = SW'(r_pool_base) + SW'(r_prod) + SW'(r_header_bytes);
    assign w_sum_a = w_sum_w[ADDR_WIDTH-1:0];
    assign w_sum   = RES_ADDR_W'(w_sum_a);

    // free / check: byte offset into the pool, wrapping at the address width
    assign w_bytes = ADDR_WIDTH'(i_s_tdata) - ADDR_WIDTH'(r_header_bytes)
                   - ADDR_WIDTH'(r_pool_base);

    assign w_in_req    = t_req'(i_s_tuser);
    assign w_in_null   = (i_s_tdata == '0);
    assign w_accept    = (r_state == S_IDLE) && i_s_tvalid;
    assign w_div_start = w_accept && (w_in_req == REQ_FREE || w_in_req == REQ_CHECK)
                      && !w_in_null && (r_block_stride != '0);

    assign w_q_range = (QW'(w_quo) >= QW'(w_eff));
    assign w_hit     = r_rdata[IW];

    fbpa_div #(
        .DW (ADDR_WIDTH),
        .VW (STRIDE_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_bytes),
        .i_divisor  (r_block_stride),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_sweep;
        w_wdata = '0;
        w_raddr = r_head;
        unique case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_waddr = r_sweep;
                w_wdata = {1'b0, w_link};
            end
            S_ALLOC: begin
                // mark taken, keep its link
                w_we    = 1'b1;
                w_waddr = r_head;
                w_wdata = {1'b1, r_rdata[IW-1:0]};
            end
            S_DIV: begin
                w_raddr = w_quo[IW-1:0];
            end
            S_LOOK: begin
                // push the freed block onto the list head
                if (w_hit && r_req == REQ_FREE) begin
                    w_we    = 1'b1;
                    w_waddr = r_idx;
                    w_wdata = {1'b0, r_head};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base    <= POOL_BASE_RST;
            r_block_stride <= BLOCK_STRIDE_RST;
            r_header_bytes <= HEADER_BYTES_RST;
            r_block_count  <= BLOCK_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_POOL_BASE:    r_pool_base    <= i_cfg_wdata[BASE_W-1:0];
                CFG_BLOCK_STRIDE: r_block_stride <= i_cfg_wdata[STRIDE_W-1:0];
                CFG_HEADER_BYTES: r_header_bytes <= i_cfg_wdata[HDR_W-1:0];
                CFG_BLOCK_COUNT:  r_block_count  <= i_cfg_wdata[COUNT_W-1:0];
            endcase
        end
    end

    // request sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sweep     <= '0;
            r_init_resp <= 1'b0;
            r_head      <= '0;
            r_free_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_prod <= w_prod;
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_sweep <= r_sweep + IW'(1);
                    if (w_sweep_last) begin
                        r_sweep    <= '0;
                        r_head     <= '0;
                        r_free_cnt <= w_eff;
                        r_res_ok   <= 1'b1;
                        r_res_addr <= '0;
                        r_res_stat <= ST_OK;
                        r_state    <= r_init_resp ? S_RESP : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_req      <= w_in_req;
                        r_res_ok   <= 1'b0;
                        r_res_addr <= '0;
                        r_res_stat <= ST_OK;
                        unique case (w_in_req)
                            REQ_ALLOC: begin
                                if (r_free_cnt == '0) begin
                                    r_res_stat <= ST_EMPTY;
                                    r_state    <= S_RESP;
                                end else begin
                                    r_state <= S_ALLOC;
                                end
                            end
                            REQ_FREE, REQ_CHECK: begin
                                if (w_in_null) begin
                                    r_res_stat <= ST_NULL;
                                    r_state    <= S_RESP;
                                end else if (r_block_stride == '0) begin
                                    r_res_stat <= ST_RANGE;
                                    r_state    <= S_RESP;
                                end else begin
                                    r_state <= S_DIV;
                                end
                            end
                            REQ_INIT: begin
                                r_init_resp <= 1'b1;
                                r_sweep     <= '0;
                                r_state     <= S_INIT;
                            end
                        endcase
                    end
                end
                S_ALLOC: begin
                    r_head     <= r_rdata[IW-1:0];
                    r_free_cnt <= r_free_cnt - CW'(1);
                    r_res_ok   <= 1'b1;
                    r_res_addr <= w_sum;
                    r_res_stat <= ST_OK;
                    r_state    <= S_RESP;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_idx <= w_quo[IW-1:0];
                        if (w_q_range) begin
                            r_res_stat <= ST_RANGE;
                            r_state    <= S_RESP;
                        end else begin
                            r_state <= S_LOOK;
                        end
                    end
                end
                S_LOOK: begin
                    if (!w_hit) begin
                        r_res_stat <= ST_NOTALLOC;
                    end else begin
                        r_res_ok <= 1'b1;
                        if (r_req == REQ_FREE) begin
                            r_head <= r_idx;
                            if (r_free_cnt < CW'(MAX_BLOCKS)) begin
                                r_free_cnt <= r_free_cnt + CW'(1);
                            end
                        end
                    end
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_tdata <= r_res_addr;
                        r_out_tuser <= {r_res_stat, r_res_ok};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_tdata;
    assign o_m_tuser  = r_out_tuser;

`ifndef NO_ASSERTIONS
    // the free count never exceeds the pool depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= CW'(MAX_BLOCKS))
        else $error("free count above pool depth");

    // a quotient only arrives while the sequencer waits for it
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

    // a successful allocate takes exactly one block off the list
    a_alloc_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC) |=> (r_free_cnt == $past(r_free_cnt) - CW'(1)))
        else $error("allocate did not decrement the free count");
`endif

endmodule

`default_nettype wire

// ===== rtl/fbpa_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle
module fbpa_div #(
    parameter int DW = 32,
    parameter int VW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_quotient
);

    localparam int CNTW = (DW > 1) ? $clog2(DW) : 1;

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_quo;
    logic [VW-1:0]   r_rem;
    logic [VW-1:0]   r_div;
    logic [VW:0]     w_trial;
    logic            w_fit;
    logic [VW:0]     w_diff;

    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[DW-2:0], w_fit};
                r_rem <= w_fit ? w_diff[VW-1:0] : w_trial[VW-1:0];
                r_cnt <= r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire
